/* hdl/fprt_pkg.sv */
// fprt_pkg: shared types and constants of the frame packet reassembly tracker
`default_nettype none
package fprt_pkg;

	localparam int TAG_W     = 8;
	localparam int SLOT_W    = 8;
	localparam int PKT_W     = 16;
	localparam int FIDX_W    = 10;
	localparam int OFFSET_W  = 27;
	localparam int PPF_W     = 16;
	localparam int FCNT_W    = 11;
	localparam int MASK_W    = 8;
	localparam int TOTAL_W   = 27;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	// frames that share one slot value lie this far apart
	localparam int SLOT_STRIDE = 256;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_PPF   = 2'd0,
		REG_FCNT  = 2'd1,
		REG_MASK  = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	localparam logic [PPF_W-1:0]  PPF_RESET  = 16'd1;
	localparam logic [FCNT_W-1:0] FCNT_RESET = 11'd1;
	localparam logic [MASK_W-1:0] MASK_RESET = 8'd0;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [SLOT_W-1:0] slot;
		logic [PKT_W-1:0]  packet_number;
	} item_t;

	typedef struct packed {
		logic [FIDX_W-1:0]   frame_index;
		logic [OFFSET_W-1:0] byte_offset;
		logic                frame_complete;
		logic                autocal_flag;
		logic                slot_overflow;
		logic                acquisition_done;
	} result_t;

endpackage
`default_nettype wire

/* hdl/fprt_ram.sv */
// fprt_ram: generic simple dual-port ram with registered read
`default_nettype none
module fprt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* hdl/frame_packet_reassembly_tracker_top.sv */
// frame_packet_reassembly_tracker_top: resolves datagram headers to frames and offsets
//
//  channel   | signals                                   | transfer when
//  ----------+-------------------------------------------+-----------------------------
//  header in | start, busy, item (tag, slot, packet no.) | start high and busy low
//  result    | done, result                              | every cycle with done high
//  config    | psel, penable, pwrite, paddr, pwdata      | psel, penable, pwrite, pready
//
//  After the header transfer the search probes frames slot, slot+256 and so on until
//  a frame takes the header or the search runs past the frame limit; each probe is
//  one registered ram read and one compare. Tally and report states follow, then the
//  done pulse. busy drops with the done pulse, so the next transfer can share that
//  edge. After reset the count table is cleared, one entry a cycle, while busy stays
//  high. The result is shown for one cycle; the receiver cannot stall.
`default_nettype none
module frame_packet_reassembly_tracker_top #(
	parameter int MAX_FRAMES    = 1024,
	parameter int PAYLOAD_BYTES = 1440
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire fprt_pkg::item_t                item,
	output logic                                done,
	output fprt_pkg::result_t                   result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [fprt_pkg::APB_AW-1:0]    paddr,
	input  wire logic [fprt_pkg::APB_DW-1:0]    pwdata,
	output logic      [fprt_pkg::APB_DW-1:0]    prdata,
	output logic                                pready
);

	import fprt_pkg::*;

	localparam int AW = $clog2(MAX_FRAMES);
	// frame numbers and the limit need room for MAX_FRAMES and a full frame_count
	localparam int CW = (AW + 1 > FCNT_W) ? AW + 1 : FCNT_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_CHECK,
		ST_TALLY,
		ST_REPORT
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [CW-1:0]       frame_q;
	logic [CW-1:0]       limit_q;
	logic [TAG_W-1:0]    tag_q;
	logic [OFFSET_W-1:0] offset_q;
	logic                found_q;
	logic                complete_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [TOTAL_W-1:0]  target_q;

	logic [PPF_W-1:0]    ppf_q;
	logic [FCNT_W-1:0]   fcnt_q;
	logic [MASK_W-1:0]   mask_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [PPF_W-1:0]    ram_wdata;
	logic [PPF_W-1:0]    ram_rdata;
	logic                cnt_room;
	logic [PPF_W:0]      cnt_inc;
	logic [CW-1:0]       fcnt_ext;
	logic [CW-1:0]       max_ext;
	reg_idx_t            reg_idx;

	// configuration registers
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppf_q  <= PPF_RESET;
			fcnt_q <= FCNT_RESET;
			mask_q <= MASK_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_PPF:  ppf_q  <= pwdata[PPF_W-1:0];
				REG_FCNT: fcnt_q <= pwdata[FCNT_W-1:0];
				REG_MASK: mask_q <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_idx)
			REG_PPF:  prdata = APB_DW'(ppf_q);
			REG_FCNT: prdata = APB_DW'(fcnt_q);
			REG_MASK: prdata = APB_DW'(mask_q);
			default:  prdata = '0;
		endcase
	end

	// probe compare and count increment on the ram read data
	assign cnt_room = (ram_rdata < ppf_q);
	assign cnt_inc  = {1'b0, ram_rdata} + (PPF_W + 1)'(1);
	assign fcnt_ext = CW'(fcnt_q);
	assign max_ext  = CW'(MAX_FRAMES);

	// count ram port control: clearing pass or count update
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = frame_q[AW-1:0];
		ram_wdata = cnt_inc[PPF_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_CHECK: ram_we = cnt_room;
			default: ;
		endcase
	end

	fprt_ram #(
		.WIDTH (PPF_W),
		.DEPTH (MAX_FRAMES)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (frame_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign busy = (state_q != ST_IDLE);

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			frame_q    <= '0;
			limit_q    <= '0;
			tag_q      <= '0;
			offset_q   <= '0;
			found_q    <= 1'b0;
			complete_q <= 1'b0;
			total_q    <= '0;
			target_q   <= '0;
			done       <= 1'b0;
			result     <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == {AW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						frame_q    <= CW'(item.slot);
						limit_q    <= (fcnt_ext < max_ext) ? fcnt_ext : max_ext;
						tag_q      <= item.tag;
						offset_q   <= OFFSET_W'(item.packet_number * PAYLOAD_BYTES);
						found_q    <= 1'b0;
						complete_q <= 1'b0;
						state_q    <= ST_PROBE;
					end
				end
				// frame past the limit ends the search, else the read is under way
				ST_PROBE: begin
					if (frame_q < limit_q) begin
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_TALLY;
					end
				end
				ST_CHECK: begin
					if (cnt_room) begin
						found_q    <= 1'b1;
						complete_q <= (cnt_inc == {1'b0, ppf_q});
						state_q    <= ST_TALLY;
					end else begin
						frame_q <= frame_q + CW'(SLOT_STRIDE);
						state_q <= ST_PROBE;
					end
				end
				// saturating datagram total and the acquisition target
				ST_TALLY: begin
					if (found_q && (total_q != {TOTAL_W{1'b1}})) begin
						total_q <= total_q + TOTAL_W'(1);
					end
					target_q <= TOTAL_W'(fcnt_q) * TOTAL_W'(ppf_q);
					state_q  <= ST_REPORT;
				end
				ST_REPORT: begin
					done                    <= 1'b1;
					result.frame_index      <= found_q ? frame_q[FIDX_W-1:0] : '0;
					result.byte_offset      <= offset_q;
					result.frame_complete   <= found_q && complete_q;
					result.autocal_flag     <= |(tag_q & mask_q);
					result.slot_overflow    <= !found_q;
					result.acquisition_done <= (total_q >= target_q);
					state_q                 <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
